// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk outside reset.
`define PIDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every rising edge of clk, reset included.
`define PIDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pidc_pkg.sv =====
package pidc_pkg;

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int PERIOD_W   = 20;
    localparam int GAIN_W     = 16;
    localparam int KGAIN_W    = 20;
    localparam int CORR_W     = 16;
    localparam int ERR_W      = SAMPLE_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int MAG_W      = ERR_W;
    localparam int ES_W       = 32;
    localparam int RATE_W     = 32;

    // Stream and configuration ports.
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Divider: |diff| * 2^20 / period, one quotient bit a cycle.
    localparam int QUO_W      = MAG_W + PERIOD_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // Shift-add multiplier: signed multiplicand, unsigned multiplier bit by bit.
    localparam int MUL_AW     = 49;
    localparam int MUL_BW     = KGAIN_W;
    localparam int MUL_HW     = MUL_AW + 2;
    localparam int MUL_PW     = MUL_HW + MUL_BW;
    localparam int MUL_CNT_W  = $clog2(MUL_BW + 1);

    // Sum of the three gain products and its scaled form.
    localparam int ACC_W      = 54;
    localparam int SMAG_W     = MUL_AW - 1;
    localparam int SCALE_LSB  = 32;
    localparam int SCALE_W    = 32;

    // Saturation limits.
    localparam logic [RATE_W-1:0]  I32_MAX     = 32'h7FFF_FFFF;
    localparam logic [RATE_W-1:0]  I32_MIN     = 32'h8000_0000;
    localparam logic [CORR_W-1:0]  OUT_MAX     = 16'h7FFF;
    localparam logic [CORR_W-1:0]  OUT_MIN     = 16'h8000;
    localparam logic [SCALE_W-1:0] OUT_POS_LIM = 32'd32767;
    localparam logic [SCALE_W-1:0] OUT_NEG_LIM = 32'd32768;

    // Register defaults.
    localparam logic [GAIN_W-1:0]  OVERALL_GAIN_RST = 16'd655;
    localparam logic [KGAIN_W-1:0] PROP_GAIN_RST    = 20'd68608;
    localparam logic [KGAIN_W-1:0] DERIV_GAIN_RST   = 20'd128;
    localparam logic [KGAIN_W-1:0] INTEG_GAIN_RST   = 20'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVERALL_GAIN = 2'd0,
        REG_PROP_GAIN    = 2'd1,
        REG_DERIV_GAIN   = 2'd2,
        REG_INTEG_GAIN   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               start;
        logic [MUL_AW-1:0]  a;
        logic [MUL_BW-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic                start;
        logic [MAG_W-1:0]    mag;
        logic [PERIOD_W-1:0] period;
    } div_req_t;

endpackage

// ===== rtl/pid_correction.sv =====
// A sample word runs from S_PREP through the multiplier passes and S_DONE to its result word;
// a clear word goes straight to S_DONE. One word is in flight at a time. The shared 20-step
// shift-add multiplier runs four passes in turn (Kp, Ki, Kd, then G);
// the 37-step divider for the derivative overlaps the first two passes.
// Reset: asynchronous, active low; clears the integrator and previous error, empties the
// output register and loads the default gains.
module pid_correction
    import pidc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // target[15:0], measured[31:16], loop_period[51:32]
    input  logic                  s_tuser,   // kind: 0 sample, 1 clear
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // correction[15:0], saturated[16]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_PREP      = 9'b000000010,
        S_MUL_P     = 9'b000000100,
        S_MUL_I     = 9'b000001000,
        S_WAIT_RATE = 9'b000010000,
        S_MUL_D     = 9'b000100000,
        S_ABS       = 9'b001000000,
        S_SCALE     = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]   overall_gain_reg;
    logic [KGAIN_W-1:0]  prop_gain_reg;
    logic [KGAIN_W-1:0]  deriv_gain_reg;
    logic [KGAIN_W-1:0]  integ_gain_reg;

    logic [ERR_W-1:0]    prev_err_reg;
    logic [ES_W-1:0]     err_sum_reg;
    logic                rate_ready_reg;
    logic                m_valid_reg;

    logic [ERR_W-1:0]    e_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                diff_neg_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [ACC_W-1:0]    sum_reg;
    logic                neg_reg;
    logic                big_reg;
    logic [CORR_W-1:0]   corr_reg;
    logic                sat_reg;
    logic [CORR_W:0]     m_data_reg;

    logic                accept;
    logic                out_free;
    logic [SAMPLE_W-1:0] target_in;
    logic [SAMPLE_W-1:0] measured_in;
    logic [ERR_W-1:0]    e_in;

    logic [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]   diff_abs;
    logic [ES_W:0]       es_wide;
    logic [ES_W-1:0]     es_sat;

    logic [ACC_W-1:0]    sum_abs;
    logic [SCALE_W-1:0]  scaled;
    logic                gain_nz;
    logic                out_pos_sat;
    logic                out_neg_sat;

    logic                q_pos_sat;
    logic                q_neg_sat;
    logic [RATE_W-1:0]   q_low;

    mul_req_t            mul_req;
    logic                mul_done;
    logic [MUL_PW-1:0]   mul_prod;
    div_req_t            div_req;
    logic                div_done;
    logic [QUO_W-1:0]    div_quo;

    pidc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    pidc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign target_in   = s_tdata[SAMPLE_W-1:0];
    assign measured_in = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign e_in        = {target_in[SAMPLE_W-1], target_in}
                       - {measured_in[SAMPLE_W-1], measured_in};

    assign diff     = {e_reg[ERR_W-1], e_reg} - {prev_err_reg[ERR_W-1], prev_err_reg};
    assign diff_abs = diff[DIFF_W-1] ? -diff : diff;

    // Integrator with clamping on signed overflow.
    assign es_wide = {err_sum_reg[ES_W-1], err_sum_reg}
                   + {{(ES_W + 1 - ERR_W){e_reg[ERR_W-1]}}, e_reg};
    assign es_sat  = (es_wide[ES_W] != es_wide[ES_W-1])
                   ? (es_wide[ES_W] ? I32_MIN : I32_MAX) : es_wide[ES_W-1:0];

    // Negative rates may reach one step further than positive ones.
    assign q_pos_sat = |div_quo[QUO_W-1:RATE_W-1];
    assign q_neg_sat = (|div_quo[QUO_W-1:RATE_W])
                     || (div_quo[RATE_W-1] && (|div_quo[RATE_W-2:0]));
    assign q_low     = div_quo[RATE_W-1:0];

    assign sum_abs = sum_reg[ACC_W-1] ? -sum_reg : sum_reg;

    // A magnitude at or above 2^48 times any nonzero gain is far beyond the output range.
    assign scaled      = mul_prod[SCALE_LSB+SCALE_W-1:SCALE_LSB];
    assign gain_nz     = (overall_gain_reg != '0);
    assign out_pos_sat = !neg_reg && ((big_reg && gain_nz) || (scaled > OUT_POS_LIM));
    assign out_neg_sat = neg_reg && ((big_reg && gain_nz) || (scaled > OUT_NEG_LIM));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = s_tuser ? S_DONE : S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_MUL_P;
            end
            S_MUL_P:
            begin
                if (mul_done)
                begin
                    state_next = S_MUL_I;
                end
            end
            S_MUL_I:
            begin
                if (mul_done)
                begin
                    state_next = S_WAIT_RATE;
                end
            end
            S_WAIT_RATE:
            begin
                if (rate_ready_reg)
                begin
                    state_next = S_MUL_D;
                end
            end
            S_MUL_D:
            begin
                if (mul_done)
                begin
                    state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (mul_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Operand selection for the four multiplier passes.
    always_comb
    begin
        mul_req = '0;
        case (state_reg)
            S_PREP:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = {{(MUL_AW - ERR_W){e_reg[ERR_W-1]}}, e_reg};
                mul_req.b     = prop_gain_reg;
            end
            S_MUL_P:
            begin
                mul_req.start = mul_done;
                mul_req.a     = {{(MUL_AW - ES_W){err_sum_reg[ES_W-1]}}, err_sum_reg};
                mul_req.b     = integ_gain_reg;
            end
            S_WAIT_RATE:
            begin
                mul_req.start = rate_ready_reg;
                mul_req.a     = {{(MUL_AW - RATE_W){rate_reg[RATE_W-1]}}, rate_reg};
                mul_req.b     = deriv_gain_reg;
            end
            S_ABS:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = {1'b0, sum_abs[SMAG_W-1:0]};
                mul_req.b     = {{(MUL_BW - GAIN_W){1'b0}}, overall_gain_reg};
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    assign div_req.start  = (state_reg == S_PREP) && (diff != '0) && (period_reg != '0);
    assign div_req.mag    = diff_abs[MAG_W-1:0];
    assign div_req.period = period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            overall_gain_reg <= OVERALL_GAIN_RST;
            prop_gain_reg    <= PROP_GAIN_RST;
            deriv_gain_reg   <= DERIV_GAIN_RST;
            integ_gain_reg   <= INTEG_GAIN_RST;
            prev_err_reg     <= '0;
            err_sum_reg      <= '0;
            rate_ready_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_OVERALL_GAIN: overall_gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_PROP_GAIN:    prop_gain_reg    <= cfg_data[KGAIN_W-1:0];
                    REG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data[KGAIN_W-1:0];
                    REG_INTEG_GAIN:   integ_gain_reg   <= cfg_data[KGAIN_W-1:0];
                    default:          ;
                endcase
            end

            if (accept && s_tuser)
            begin
                prev_err_reg <= '0;
                err_sum_reg  <= '0;
            end
            else if (state_reg == S_PREP)
            begin
                prev_err_reg <= e_reg;
                err_sum_reg  <= es_sat;
            end

            if (state_reg == S_PREP)
            begin
                rate_ready_reg <= !div_req.start;
            end
            else if (div_done)
            begin
                rate_ready_reg <= 1'b1;
            end

            if ((state_reg == S_DONE) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_reg      <= e_in;
            period_reg <= s_tdata[2*SAMPLE_W+PERIOD_W-1:2*SAMPLE_W];
            corr_reg   <= '0;
            sat_reg    <= 1'b0;
        end

        if (state_reg == S_PREP)
        begin
            sum_reg      <= '0;
            diff_neg_reg <= diff[DIFF_W-1];
            if (diff == '0)
            begin
                rate_reg <= '0;
            end
            else if (period_reg == '0)
            begin
                rate_reg <= diff[DIFF_W-1] ? I32_MIN : I32_MAX;
                sat_reg  <= 1'b1;
            end
        end

        if (div_done)
        begin
            if (!diff_neg_reg && q_pos_sat)
            begin
                rate_reg <= I32_MAX;
                sat_reg  <= 1'b1;
            end
            else if (diff_neg_reg && q_neg_sat)
            begin
                rate_reg <= I32_MIN;
                sat_reg  <= 1'b1;
            end
            else
            begin
                rate_reg <= diff_neg_reg ? -q_low : q_low;
            end
        end

        if (mul_done && ((state_reg == S_MUL_P) || (state_reg == S_MUL_I)
                         || (state_reg == S_MUL_D)))
        begin
            sum_reg <= sum_reg + mul_prod[ACC_W-1:0];
        end

        if (state_reg == S_ABS)
        begin
            neg_reg <= sum_reg[ACC_W-1];
            big_reg <= |sum_abs[ACC_W-1:SMAG_W];
        end

        if ((state_reg == S_SCALE) && mul_done)
        begin
            if (out_pos_sat)
            begin
                corr_reg <= OUT_MAX;
                sat_reg  <= 1'b1;
            end
            else if (out_neg_sat)
            begin
                corr_reg <= OUT_MIN;
                sat_reg  <= 1'b1;
            end
            else
            begin
                corr_reg <= neg_reg ? -scaled[CORR_W-1:0] : scaled[CORR_W-1:0];
            end
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            m_data_reg <= {sat_reg, corr_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - CORR_W - 1){1'b0}}, m_data_reg};

endmodule

// ===== rtl/pidc_div.sv =====
module pidc_div
    import pidc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [QUO_W-1:0]     dvd_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [PERIOD_W-1:0]  rem_reg;
    logic [PERIOD_W-1:0]  dsr_reg;

    logic [PERIOD_W:0]    trial;
    logic [PERIOD_W:0]    trial_sub;
    logic                 fits;
    logic [PERIOD_W-1:0]  rem_next;

    // Restoring division: the dividend shifts in one bit a cycle, MSB first.
    assign trial     = {rem_reg, dvd_reg[QUO_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign fits      = trial >= {1'b0, dsr_reg};
    assign rem_next  = fits ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= {req.mag, {PERIOD_W{1'b0}}};
            dsr_reg <= req.period;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/pidc_mul.sv =====
module pidc_mul
    import pidc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mul_req_t          req,
    output logic              done,
    output logic [MUL_PW-1:0] product
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_AW-1:0]    a_reg;
    logic [MUL_BW-1:0]    b_reg;
    logic [MUL_PW-1:0]    acc_reg;

    logic [MUL_HW-1:0]    addend;
    logic [MUL_HW-1:0]    upper;
    logic [MUL_PW-1:0]    acc_next;

    // One multiplier bit a cycle, LSB first. The partial sum shifts right so
    // only the upper part ever sees the adder.
    assign addend   = b_reg[0] ? {{(MUL_HW - MUL_AW){a_reg[MUL_AW-1]}}, a_reg} : '0;
    assign upper    = acc_reg[MUL_PW-1:MUL_BW] + addend;
    assign acc_next = {upper[MUL_HW-1], upper, acc_reg[MUL_BW-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= MUL_CNT_W'(MUL_BW);
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == MUL_CNT_W'(1));
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - MUL_CNT_W'(1);
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= {1'b0, b_reg[MUL_BW-1:1]};
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/pidc_checker.sv =====
`include "assert_macros.svh"

module pidc_checker
    import pidc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TDATA_W-1:0]  s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // A result word that is not taken stays put.
    `PIDC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // Only one word is worked on at a time.
    `PIDC_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

    // Handing a result to the output register frees the input side.
    `PIDC_ASSERT(a_out_frees_in, $rose(m_tvalid) |-> s_tready, "input blocked after result loaded")

    // A clear word with an empty output register answers zero: it goes to S_DONE, then into the output register.
    `PIDC_ASSERT(a_clear_zero, s_tvalid && s_tready && s_tuser && !m_tvalid |-> ##2 (m_tvalid && (m_tdata[CORR_W:0] == '0)), "clear word gave a nonzero result")

    // In the cycle after reset is seen low, the output is empty and the input is open.
    `PIDC_ASSERT_ALWAYS(a_reset_state, !rst_n |=> !m_tvalid && s_tready, "bad state in reset")

endmodule

bind pid_correction pidc_checker u_pidc_checker (.*);
